@@ hdl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions for the byte stream sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned FILL_W   = 6;
	localparam int unsigned ROUND_W  = 6;
	localparam int unsigned BLOCK_W  = 512;
	localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
	localparam logic [FILL_W-1:0] LEN_START = 6'd56;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_INIT,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      shift_byte;
		byte_sel_t byte_sel;
		logic      count_msg;
		logic      load_len;
		logic      shift_len;
		logic      init_work;
		logic      round_en;
		logic      update_hash;
		logic      emit;
	} cmd_t;

	typedef struct packed {
		logic fill_full;
		logic fill_len;
		logic round_last;
	} status_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

@@ hdl/sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 over a byte stream, one byte per input beat, digest as four 64-bit words
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  -----------------------------------------
//  input    in_valid / in_stall  data_byte, has_byte, last
//  output   out_valid/out_stall  digest_word0 .. digest_word3 (big-endian)
//
//  every 64th byte starts a compression (load working vars, 64 rounds through
//  one shared round unit, hash update); in_stall holds off further bytes until
//  the compression is done
//  a last beat is followed by the pad, zero and length bytes up to the block
//  end, then one or two compressions and the digest load
//  reset clears the sequencer and byte counters and loads the initial hash values at once
//  a waiting digest does not hold off the next message; only a second digest
//  waits for the output register to drain
//
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word0,
	output logic [63:0] digest_word1,
	output logic [63:0] digest_word2,
	output logic [63:0] digest_word3
);
	import sha_pkg::*;

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t sts;

	// sequencer: intake, padding walk, round count and digest hand-off
	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.has_byte  (has_byte),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: 512-bit block line doubling as the rolling schedule window
	sha_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.data_byte    (data_byte),
		.digest_word0 (digest_word0),
		.digest_word1 (digest_word1),
		.digest_word2 (digest_word2),
		.digest_word3 (digest_word3)
	);

	// a fresh digest never overwrites one still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && out_valid && out_stall))
		else $error("digest loaded over a waiting result");

	// byte intake and round shifting never share the block line
	a_line_owner: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.shift_byte, cmd.round_en, cmd.init_work, cmd.update_hash}))
		else $error("conflicting datapath commands");

	// hash update only right after the last round
	a_update_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update_hash |-> ($past(cmd.round_en) && $past(sts.round_last)))
		else $error("hash update without a finished round sequence");

	// loading a digest always raises the output valid
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("digest loaded but not offered");

endmodule

@@ hdl/sha_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer: byte intake, padding, compression rounds and digest hand-off
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             has_byte,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_stall,
	input  sha_pkg::status_t sts,
	output sha_pkg::cmd_t    cmd
);
	import sha_pkg::*;

	state_t state_q, state_d;
	logic   fin_q, fin_d;
	logic   pad_done_q, pad_done_d;
	logic   len_phase_q, len_phase_d;
	logic   final_q, final_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b0;
			pad_done_q  <= 1'b0;
			len_phase_q <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fin_q       <= fin_d;
			pad_done_q  <= pad_done_d;
			len_phase_q <= len_phase_d;
			final_q     <= final_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		fin_d       = fin_q;
		pad_done_d  = pad_done_q;
		len_phase_d = len_phase_q;
		final_d     = final_q;
		cmd         = '0;
		cmd.byte_sel = SEL_DATA;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.shift_byte = has_byte;
					cmd.count_msg  = has_byte;
					fin_d          = last;
					if (has_byte && sts.fill_full) begin
						state_d = ST_INIT;
					end else if (last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.shift_byte = 1'b1;
				if (!pad_done_q) begin
					cmd.byte_sel = SEL_PAD;
					cmd.load_len = 1'b1;
					pad_done_d   = 1'b1;
				end else if (len_phase_q || sts.fill_len) begin
					cmd.byte_sel  = SEL_LEN;
					cmd.shift_len = 1'b1;
					len_phase_d   = 1'b1;
				end else begin
					cmd.byte_sel = SEL_ZERO;
				end
				if (sts.fill_full) begin
					state_d = ST_INIT;
					final_d = (cmd.byte_sel == SEL_LEN);
				end
			end
			ST_INIT: begin
				cmd.init_work = 1'b1;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (sts.round_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update_hash = 1'b1;
				if (final_q) begin
					state_d = ST_EMIT;
				end else if (fin_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit    = 1'b1;
					state_d     = ST_IDLE;
					fin_d       = 1'b0;
					pad_done_d  = 1'b0;
					len_phase_d = 1'b0;
					final_d     = 1'b0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid_d = cmd.emit | (out_valid_q & out_stall);
	assign out_valid   = out_valid_q;
	assign in_stall    = (state_q != ST_IDLE);

endmodule

@@ hdl/sha_dp.sv @@
// ----------------------------------------------------------------------------
// sha_dp
// block shift line, message schedule, round logic, hash state and digest register
// ----------------------------------------------------------------------------
module sha_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  sha_pkg::cmd_t    cmd,
	output sha_pkg::status_t sts,
	input  logic [7:0]       data_byte,
	output logic [63:0]      digest_word0,
	output logic [63:0]      digest_word1,
	output logic [63:0]      digest_word2,
	output logic [63:0]      digest_word3
);
	import sha_pkg::*;

	logic [BLOCK_W-1:0] blk_q;
	logic [FILL_W-1:0]  fill_q;
	logic [ROUND_W-1:0] round_q;
	logic [63:0]        msg_q;
	logic [63:0]        len_q;
	logic [31:0]        hash_q [8];
	logic [31:0]        wv_q [8];
	logic [63:0]        dig_q [4];

	logic [7:0]  byte_in;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2;

	// window word i sits at the top end first
	assign w0  = blk_q[BLOCK_W-1      -: 32];
	assign w1  = blk_q[BLOCK_W-1-32   -: 32];
	assign w9  = blk_q[BLOCK_W-1-288  -: 32];
	assign w14 = blk_q[BLOCK_W-1-448  -: 32];
	assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;

	assign t1 = wv_q[7] + big_sig1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
		+ K_TABLE[round_q] + w0;
	assign t2 = big_sig0(wv_q[0])
		+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

	always_comb begin
		unique case (cmd.byte_sel)
			SEL_DATA: byte_in = data_byte;
			SEL_PAD:  byte_in = PAD_BYTE;
			SEL_ZERO: byte_in = 8'h00;
			SEL_LEN:  byte_in = len_q[63:56];
			default:  byte_in = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			round_q <= '0;
			msg_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= IV[i];
			end
		end else begin
			if (cmd.shift_byte) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.init_work) begin
				round_q <= '0;
			end else if (cmd.round_en) begin
				round_q <= round_q + 1'b1;
			end
			if (cmd.emit) begin
				msg_q <= '0;
			end else if (cmd.count_msg) begin
				msg_q <= msg_q + 64'd1;
			end
			for (int i = 0; i < 8; i++) begin
				if (cmd.emit) begin
					hash_q[i] <= IV[i];
				end else if (cmd.update_hash) begin
					hash_q[i] <= hash_q[i] + wv_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			blk_q <= {blk_q[BLOCK_W-9:0], byte_in};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[BLOCK_W-33:0], w_new};
		end
		if (cmd.load_len) begin
			len_q <= {msg_q[60:0], 3'b000};
		end else if (cmd.shift_len) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (cmd.init_work) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= hash_q[i];
			end
		end else if (cmd.round_en) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
		if (cmd.emit) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= {hash_q[2*i], hash_q[2*i+1]};
			end
		end
	end

	assign sts.fill_full  = (fill_q == FILL_LAST);
	assign sts.fill_len   = (fill_q == LEN_START);
	assign sts.round_last = (round_q == ROUND_LAST);

	assign digest_word0 = dig_q[0];
	assign digest_word1 = dig_q[1];
	assign digest_word2 = dig_q[2];
	assign digest_word3 = dig_q[3];

endmodule

@@ tb/sha256_digest_checker.sv @@
// ----------------------------------------------------------------------------
// sha256_digest_checker
// watches both channels of the byte stream hasher, keeps its own sha-256
// model of each finished message and compares every digest beat against the oldest one
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] digest_word0,
	input  logic [63:0] digest_word1,
	input  logic [63:0] digest_word2,
	input  logic [63:0] digest_word3,
	input  logic        end_check,
	output int          fails,
	output int          pending,
	output int          digests_seen
);

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [255:0] START_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [255:0] digest_queue [$];
	logic [255:0] chain_hash;
	logic [511:0] block_bytes;
	int           fill_cnt;
	logic [63:0]  msg_len;
	logic         end_done;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one compression of a 512-bit block, byte 0 in the top bits
	function automatic logic [255:0] compress(input logic [255:0] hv, input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = blk[511 - 32*i -: 32];
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		{a, b, c, d, e, f, g, h} = hv;
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_CONST[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		return {hv[255:224] + a, hv[223:192] + b, hv[191:160] + c, hv[159:128] + d,
			hv[127:96] + e, hv[95:64] + f, hv[63:32] + g, hv[31:0] + h};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [255:0] want, got;
		if (!arst_n) begin
			digest_queue.delete();
			chain_hash   = START_HASH;
			fill_cnt     = 0;
			msg_len      = '0;
			fails        = 0;
			digests_seen = 0;
			end_done     = 1'b0;
		end else begin
			// input beat: fold the byte in, finish the message on last
			if (in_valid && !in_stall) begin
				if (has_byte) begin
					block_bytes[511 - 8*fill_cnt -: 8] = data_byte;
					msg_len  = msg_len + 64'd1;
					fill_cnt = fill_cnt + 1;
					if (fill_cnt == 64) begin
						chain_hash = compress(chain_hash, block_bytes);
						fill_cnt   = 0;
					end
				end
				if (last) begin
					block_bytes[511 - 8*fill_cnt -: 8] = 8'h80;
					fill_cnt = fill_cnt + 1;
					// no room for the length field, spill into one more block
					if (fill_cnt > 56) begin
						for (int i = fill_cnt; i < 64; i++)
							block_bytes[511 - 8*i -: 8] = 8'h00;
						chain_hash = compress(chain_hash, block_bytes);
						fill_cnt   = 0;
					end
					for (int i = fill_cnt; i < 56; i++)
						block_bytes[511 - 8*i -: 8] = 8'h00;
					block_bytes[63:0] = msg_len << 3;
					chain_hash = compress(chain_hash, block_bytes);
					digest_queue.push_back(chain_hash);
					chain_hash = START_HASH;
					fill_cnt   = 0;
					msg_len    = '0;
				end
			end
			// digest beat against the oldest finished message
			if (out_valid && !out_stall) begin
				got = {digest_word0, digest_word1, digest_word2, digest_word3};
				if (digest_queue.size() == 0) begin
					$error("digest beat %h with no message finished", got);
					fails = fails + 1;
				end else begin
					want = digest_queue.pop_front();
					digests_seen = digests_seen + 1;
					for (int i = 0; i < 4; i++) begin
						if (got[255 - 64*i -: 64] !== want[255 - 64*i -: 64]) begin
							$error("digest_word%0d: expected %h, actual %h", i,
								want[255 - 64*i -: 64], got[255 - 64*i -: 64]);
							fails = fails + 1;
						end
					end
				end
			end
			if (end_check && !end_done) begin
				end_done = 1'b1;
				if (digest_queue.size() != 0) begin
					$error("%0d digests never delivered", digest_queue.size());
					fails = fails + digest_queue.size();
				end
			end
		end
		pending = digest_queue.size();
	end

endmodule

@@ tb/tb_sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// drives byte streams of random and boundary lengths into the hasher with
// random gaps and output back-pressure; the checker beside the block predicts
// and compares every digest, this module only makes stimulus and the verdict
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;

	import sha_pkg::*;

	// longest stretch with no beat on either channel before giving up
	localparam int STALL_LIMIT = 5000;
	// cycles to keep watching once the last digest has arrived
	localparam int TAIL_CYCLES = 300;
	localparam int BEAT_GOAL   = 1500;
	localparam int CALM_AFTER  = 1300;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte  = 1'b0;
	logic        last      = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] digest_word0;
	logic [63:0] digest_word1;
	logic [63:0] digest_word2;
	logic [63:0] digest_word3;
	logic        end_check = 1'b0;

	int fails;
	int pending;
	int digests_seen;
	int beat_cnt  = 0;
	int msg_cnt   = 0;
	int idle_run  = 0;
	int stall_left = 0;
	bit calm      = 1'b0;

	always #5 clk = ~clk;

	sha256_byte_stream_hasher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word0 (digest_word0),
		.digest_word1 (digest_word1),
		.digest_word2 (digest_word2),
		.digest_word3 (digest_word3)
	);

	sha256_digest_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word0 (digest_word0),
		.digest_word1 (digest_word1),
		.digest_word2 (digest_word2),
		.digest_word3 (digest_word3),
		.end_check    (end_check),
		.fails        (fails),
		.pending      (pending),
		.digests_seen (digests_seen)
	);

	// digest side back-pressure: random bursts of stall, none once calm
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog: any beat on either channel restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (idle_run >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// one input beat; called at a rising edge, returns at the accepting edge
	task automatic send_beat(input logic [7:0] d, input logic hb, input logic lst);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= d;
		has_byte  <= hb;
		last      <= lst;
		// stall is settled by the falling edge, inputs only move on rising ones
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
		if (hb || lst)
			beat_cnt++;
		if (lst)
			msg_cnt++;
	endtask

	// hold the sender off until every finished message has its digest back
	task automatic wait_digests_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// a message of len bytes; the last byte carries last, or a byteless
	// closing beat follows; an ignored beat slips in now and then
	task automatic send_message(input int len, input bit close_on_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
		end
		if (!close_on_byte || len == 0)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin : stimulus
		int len;
		int pick;
		int edge_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message: last with no byte
		send_beat(8'h00, 1'b0, 1'b1);
		// short message closed by its final byte
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		// ignored beat with all data bits set, then extreme bytes
		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		// byteless last with junk on data_byte
		send_beat(8'h5a, 1'b0, 1'b1);
		// one-byte messages of each extreme
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		// back to back byteless lasts
		send_beat(8'hff, 1'b0, 1'b1);
		send_beat(8'h00, 1'b0, 1'b1);

		// sender pause until all digests are home
		wait_digests_drained();

		// random messages, mostly short, a fair share around block boundaries
		while (beat_cnt < BEAT_GOAL || msg_cnt < 40) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				len = $urandom_range(0, 20);
			else if (pick < 85)
				len = edge_lens[$urandom_range(0, 9)];
			else
				len = $urandom_range(0, 150);
			send_message(len, $urandom_range(0, 1) == 1);
			if (msg_cnt % 8 == 0)
				wait_digests_drained();
			if (beat_cnt >= CALM_AFTER)
				calm = 1'b1;
		end

		wait_digests_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);

		$display("covered %0d messages in %0d data and last beats, %0d digests compared",
			msg_cnt, beat_cnt, digests_seen);
		$display("lengths spanned empty, short and block-boundary messages under random gaps");
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
